/* design/pot_pkg.sv */
// ----------------------------------------------------------------------------
// pot_pkg
// shared widths, operation codes and helpers for the port ownership table
// ----------------------------------------------------------------------------
package pot_pkg;

    // field widths
    localparam int FUNC_W        = 3;
    localparam int OWNER_ID_BITS = 8;
    localparam int PORT_W        = 16;

    // stream payload widths, padded to whole bytes
    localparam int IN_FIELDS_W  = FUNC_W + OWNER_ID_BITS + 2 * PORT_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 1 + OWNER_ID_BITS + PORT_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    // config port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // table geometry and search constants
    localparam logic [PORT_W-1:0] PORT_TOP    = 16'hFFFF;
    localparam logic [PORT_W-1:0] FLOOR_RESET = 16'd1000;
    localparam logic [PORT_W-1:0] SEARCH_STEP = 16'd2;
    localparam logic [PORT_W-1:0] UP_LIMIT    = PORT_TOP - SEARCH_STEP;

    // register index, taken from paddr[2]
    typedef enum logic {
        REG_FLOOR   = 1'b0,
        REG_CEILING = 1'b1
    } t_reg_idx;

    // operation codes
    typedef enum logic [FUNC_W-1:0] {
        FN_CLAIM_PAIR   = 3'd0,
        FN_CLAIM_ONE    = 3'd1,
        FN_RELEASE_PAIR = 3'd2,
        FN_RELEASE_ONE  = 3'd3,
        FN_QUERY        = 3'd4,
        FN_FIND_FREE    = 3'd5
    } t_func;

    typedef logic [OWNER_ID_BITS-1:0] t_owner;
    typedef logic [PORT_W-1:0]        t_port;

    // a port may be claimed when free or already held by the caller
    function automatic logic may_claim(input t_owner cur, input t_owner id);
        return (cur == '0) || (cur == id);
    endfunction

    // a port may be released only when held by the caller with a nonzero id
    function automatic logic may_release(input t_owner cur, input t_owner id);
        return (cur != '0) && (cur == id);
    endfunction

endpackage

/* design/port_ownership_table.sv */
// ----------------------------------------------------------------------------
// port_ownership_table
// owner id table over all 16-bit ports with claim, release, query and search
// ----------------------------------------------------------------------------
// Requests arrive on the s_ stream, one transfer per operation; every request
// produces exactly one result transfer on the m_ stream. The APB port holds
// the search floor (address 0) and search ceiling (address 4); write them only
// while no request is in flight.
// The table is a single-port 64K x 8 memory with a registered read, driven by
// a small sequencer. Claim, release and query read port_b, then evaluate and
// write port_a, then hand the result to the result register; the pairs also
// write port_b in a state of their own before the hand-over. The next request
// is taken only once the sequencer is back in idle. Find free adds a bound
// check and a probe per candidate, so each step outward on both sides passes
// the bound check, the upward probe and the downward probe.
// After reset the memory is cleared by a pass over all 65536 entries, one
// entry per cycle; s_tready stays low for those cycles, APB writes still land.
// The result register parts the two sides: a new request is accepted while a
// result waits; if m_tready is held low the finished next result waits in the
// sequencer and s_tready stays low until the result register frees up.
// ----------------------------------------------------------------------------
module port_ownership_table (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // request stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // fields from bit 0: func[3], owner_id[8], port_a[16], port_b[16], zero pad
    input  logic [pot_pkg::IN_TDATA_W-1:0]    s_tdata,
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // fields from bit 0: success[1], owner_found[8], port_found[16], zero pad
    output logic [pot_pkg::OUT_TDATA_W-1:0]   m_tdata,
    // configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [pot_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [pot_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [pot_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);
    import pot_pkg::*;

    localparam int DEPTH = 1 << PORT_W;

    typedef enum logic [8:0] {
        ST_CLEAR = 9'b000000001,
        ST_IDLE  = 9'b000000010,
        ST_RD_B  = 9'b000000100,
        ST_EVAL  = 9'b000001000,
        ST_WR_B  = 9'b000010000,
        ST_S_CHK = 9'b000100000,
        ST_S_UP  = 9'b001000000,
        ST_S_DN  = 9'b010000000,
        ST_DONE  = 9'b100000000
    } t_state;

    // control registers
    t_state r_state, n_state;
    t_port  r_clr;
    logic   r_out_valid, n_out_valid;

    // config registers
    t_port  r_floor;
    t_port  r_ceil;

    // request and working registers
    logic [FUNC_W-1:0] r_func, n_func;
    t_owner r_id, n_id;
    t_port  r_pa, n_pa;
    t_port  r_pb, n_pb;
    t_owner r_own_a, n_own_a;
    t_port  r_up, n_up;
    t_port  r_down, n_down;
    logic   r_dn_live, n_dn_live;
    logic   r_wr_b, n_wr_b;
    t_owner r_wd_b, n_wd_b;

    // pending result and output register
    logic   r_res_ok, n_res_ok;
    t_owner r_res_owner, n_res_owner;
    t_port  r_res_found, n_res_found;
    logic   r_out_ok, n_out_ok;
    t_owner r_out_owner, n_out_owner;
    t_port  r_out_found, n_out_found;

    // memory port
    t_owner mem [DEPTH];
    t_owner r_rdata;
    t_port  mem_addr;
    logic   mem_we;
    t_owner mem_wd;

    // unpacked request fields
    logic [FUNC_W-1:0] in_func;
    t_owner in_id;
    t_port  in_pa;
    t_port  in_pb;

    logic   in_xfer;
    logic   out_xfer;
    logic   cfg_wr;
    logic   up_live;
    logic   down_live;
    logic   ok_a;
    logic   ok_b;
    logic   rel_a;
    logic   rel_b;

    assign in_func = s_tdata[FUNC_W-1:0];
    assign in_id   = s_tdata[FUNC_W +: OWNER_ID_BITS];
    assign in_pa   = s_tdata[FUNC_W+OWNER_ID_BITS +: PORT_W];
    assign in_pb   = s_tdata[FUNC_W+OWNER_ID_BITS+PORT_W +: PORT_W];

    assign s_tready = (r_state == ST_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign m_tvalid = r_out_valid;
    assign out_xfer = r_out_valid && m_tready;
    assign m_tdata  = {{(OUT_TDATA_W-OUT_FIELDS_W){1'b0}}, r_out_found, r_out_owner, r_out_ok};

    // apb access, always ready
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (t_reg_idx'(paddr[2]) == REG_CEILING) ?
                    {{(APB_DATA_W-PORT_W){1'b0}}, r_ceil} :
                    {{(APB_DATA_W-PORT_W){1'b0}}, r_floor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_floor <= FLOOR_RESET;
            r_ceil  <= PORT_TOP;
        end else if (cfg_wr) begin
            case (t_reg_idx'(paddr[2]))
                REG_FLOOR:   r_floor <= pwdata[PORT_W-1:0];
                REG_CEILING: r_ceil  <= pwdata[PORT_W-1:0];
                default:     r_floor <= r_floor;
            endcase
        end
    end

    // claim and release checks on the two captured owners
    assign ok_a  = may_claim(r_own_a, r_id);
    assign ok_b  = may_claim(r_rdata, r_id);
    assign rel_a = may_release(r_own_a, r_id);
    assign rel_b = may_release(r_rdata, r_id) && (r_pa != r_pb);

    // search bounds for the current candidates
    assign up_live   = (r_up < r_ceil) && (r_up <= UP_LIMIT);
    assign down_live = (r_down > r_floor) && (r_down >= SEARCH_STEP);

    // memory address and write selection
    always_comb begin
        mem_addr = r_pa;
        mem_we   = 1'b0;
        mem_wd   = '0;
        case (r_state)
            ST_CLEAR: begin
                mem_addr = r_clr;
                mem_we   = 1'b1;
            end
            ST_IDLE:  mem_addr = in_pa;
            ST_RD_B:  mem_addr = r_pb;
            ST_EVAL: begin
                mem_addr = r_pa;
                case (t_func'(r_func))
                    FN_CLAIM_PAIR: begin
                        mem_we = ok_a && ok_b;
                        mem_wd = r_id;
                    end
                    FN_CLAIM_ONE: begin
                        mem_we = ok_a;
                        mem_wd = r_id;
                    end
                    FN_RELEASE_PAIR, FN_RELEASE_ONE: begin
                        mem_we = rel_a;
                    end
                    default: mem_we = 1'b0;
                endcase
            end
            ST_WR_B: begin
                mem_addr = r_pb;
                mem_we   = r_wr_b;
                mem_wd   = r_wd_b;
            end
            ST_S_CHK: mem_addr = up_live ? (r_up + SEARCH_STEP) : (r_down - SEARCH_STEP);
            ST_S_UP:  mem_addr = r_down - SEARCH_STEP;
            default:  mem_addr = r_pa;
        endcase
    end

    // owner table, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wd;
        end
        r_rdata <= mem[mem_addr];
    end

    // sequencer next state
    always_comb begin
        n_state     = r_state;
        n_func      = r_func;
        n_id        = r_id;
        n_pa        = r_pa;
        n_pb        = r_pb;
        n_own_a     = r_own_a;
        n_up        = r_up;
        n_down      = r_down;
        n_dn_live   = r_dn_live;
        n_wr_b      = r_wr_b;
        n_wd_b      = r_wd_b;
        n_res_ok    = r_res_ok;
        n_res_owner = r_res_owner;
        n_res_found = r_res_found;
        n_out_valid = r_out_valid && !out_xfer;
        n_out_ok    = r_out_ok;
        n_out_owner = r_out_owner;
        n_out_found = r_out_found;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr == PORT_TOP) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_xfer) begin
                    n_func  = in_func;
                    n_id    = in_id;
                    n_pa    = in_pa;
                    n_pb    = in_pb;
                    n_state = ST_RD_B;
                end
            end
            ST_RD_B: begin
                n_own_a = r_rdata;
                n_state = ST_EVAL;
            end
            ST_EVAL: begin
                n_res_ok    = 1'b0;
                n_res_owner = '0;
                n_res_found = '0;
                n_wr_b      = 1'b0;
                n_wd_b      = '0;
                n_state     = ST_DONE;
                case (t_func'(r_func))
                    FN_CLAIM_PAIR: begin
                        n_res_ok = ok_a && ok_b;
                        n_wr_b   = ok_a && ok_b;
                        n_wd_b   = r_id;
                        n_state  = ST_WR_B;
                    end
                    FN_CLAIM_ONE:   n_res_ok = ok_a;
                    FN_RELEASE_PAIR: begin
                        n_res_ok = rel_a && rel_b;
                        n_wr_b   = rel_b;
                        n_state  = ST_WR_B;
                    end
                    FN_RELEASE_ONE: n_res_ok = rel_a;
                    FN_QUERY:       n_res_owner = r_own_a;
                    FN_FIND_FREE: begin
                        if (ok_a) begin
                            n_res_ok    = 1'b1;
                            n_res_found = r_pa;
                        end else begin
                            n_up    = r_pa;
                            n_down  = r_pa;
                            n_state = ST_S_CHK;
                        end
                    end
                    default: n_res_ok = 1'b0;
                endcase
            end
            ST_WR_B: n_state = ST_DONE;
            // bound check, then step up first and down second
            ST_S_CHK: begin
                n_dn_live = down_live;
                if (up_live) begin
                    n_up    = r_up + SEARCH_STEP;
                    n_state = ST_S_UP;
                end else if (down_live) begin
                    n_down  = r_down - SEARCH_STEP;
                    n_state = ST_S_DN;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_S_UP: begin
                if (may_claim(r_rdata, r_id)) begin
                    n_res_ok    = 1'b1;
                    n_res_found = r_up;
                    n_state     = ST_DONE;
                end else if (r_dn_live) begin
                    n_down  = r_down - SEARCH_STEP;
                    n_state = ST_S_DN;
                end else begin
                    n_state = ST_S_CHK;
                end
            end
            ST_S_DN: begin
                if (may_claim(r_rdata, r_id)) begin
                    n_res_ok    = 1'b1;
                    n_res_found = r_down;
                    n_state     = ST_DONE;
                end else begin
                    n_state = ST_S_CHK;
                end
            end
            // hand the result over once the output register is free
            ST_DONE: begin
                if (!r_out_valid || out_xfer) begin
                    n_out_valid = 1'b1;
                    n_out_ok    = r_res_ok;
                    n_out_owner = r_res_owner;
                    n_out_found = r_res_found;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= r_clr + ((r_state == ST_CLEAR) ? t_port'(1) : t_port'(0));
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_func      <= n_func;
        r_id        <= n_id;
        r_pa        <= n_pa;
        r_pb        <= n_pb;
        r_own_a     <= n_own_a;
        r_up        <= n_up;
        r_down      <= n_down;
        r_dn_live   <= n_dn_live;
        r_wr_b      <= n_wr_b;
        r_wd_b      <= n_wd_b;
        r_res_ok    <= n_res_ok;
        r_res_owner <= n_res_owner;
        r_res_found <= n_res_found;
        r_out_ok    <= n_out_ok;
        r_out_owner <= n_out_owner;
        r_out_found <= n_out_found;
    end

    // a transfer in is followed by a busy cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> !s_tready)
        else $error("request accepted back to back");

    // no result appears while the table is being cleared
    a_no_result_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !m_tvalid)
        else $error("result during clearing pass");

    // the search never writes the table
    a_search_read_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_S_CHK) || (r_state == ST_S_UP) || (r_state == ST_S_DN)) |-> !mem_we)
        else $error("table write during search");

    // a found port is an even step from the desired port
    a_found_parity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_DONE) && r_res_ok && (t_func'(r_func) == FN_FIND_FREE))
            |-> (r_res_found[0] == r_pa[0]))
        else $error("found port off the search grid");

endmodule
